// ===== rtl/core/cubic_bezier_flattener_macros.svh =====
// assertion macros shared by the cubic bezier flattener rtl
`ifndef CUBIC_BEZIER_FLATTENER_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cbf_pkg.sv =====
// shared types, constants and helpers for the cubic bezier flattener
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  localparam int MAX_DEPTH = 6;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int DIST_W    = COORD_W + 2;
  localparam int FRAC_W    = 16;
  localparam int WHOLE_W   = DIST_W + 1 - FRAC_W;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LG_W      = $clog2(WHOLE_W) + 1;
  localparam logic [FRAC_W-1:0] ROUND_ADD = {FRAC_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } out_item_t;

  typedef struct packed {
    coord_t [3:0]       x;
    coord_t [3:0]       y;
    logic [DEPTH_W-1:0] depth;
  } seg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MID,
    OP_DIFF,
    OP_ABS,
    OP_OCTA,
    OP_MAX,
    OP_ROUND,
    OP_DEPTH,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic leaf;
    logic stack_empty;
    logic out_free;
  } status_t;

  // floor of the mean, sum kept at full width
  function automatic coord_t avg2(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

  // larger axis term plus half the smaller
  function automatic logic [DIST_W-1:0] octa(input logic [DIFF_W-1:0] a,
                                             input logic [DIFF_W-1:0] b);
    logic [DIST_W-1:0] r;
    if (a > b) begin
      r = {1'b0, a} + {2'b00, b[DIFF_W-1:1]};
    end else begin
      r = {1'b0, b} + {2'b00, a[DIFF_W-1:1]};
    end
    return r;
  endfunction

  // floor(log2)/2 + 1, capped; zero and one both count as log 0
  function automatic logic [DEPTH_W-1:0] depth_of(input logic [WHOLE_W-1:0] whole);
    logic [LG_W-1:0] lg;
    logic [LG_W-1:0] cnt;
    lg = '0;
    for (int i = 1; i < WHOLE_W; i++) begin
      if (whole[i]) begin
        lg = LG_W'(i);
      end
    end
    cnt = (lg >> 1) + LG_W'(1);
    if (cnt > LG_W'(MAX_DEPTH)) begin
      cnt = LG_W'(MAX_DEPTH);
    end
    return cnt[DEPTH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cubic_bezier_flattener.sv =====
// top level of the cubic bezier flattener: controller plus datapath
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | in        | in_valid_i/in_stall_o   | in_data_i: four 16.16 points
//   out     | out       | out_valid_o/out_stall_i | out_data_o: vertex, last flag
//
// one curve at a time: an input transfer, the estimate steps (midpoint, difference,
// magnitude, octagonal distance, maximum, rounding, depth), then a split pass per
// split and an emit per vertex, plus any time the output spends stalled
// the split is a pass through two banks of averagers, and vertices leave through
// a single output register, which holds its vertex while the output is stalled
// the last vertex may still wait in the output register while the next curve
// is taken in; no clearing pass after reset, the segment stack is always
// written before it is read
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_flattener (
  input  wire                     logic clk_i,
  input  wire                     logic rst_ni,
  input  wire                     logic in_valid_i,
  output logic                    in_stall_o,
  input  wire cbf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     logic out_stall_i,
  output cbf_pkg::out_item_t      out_data_o
);

  // command and status between the two halves
  cbf_pkg::cmd_t    cmd;
  cbf_pkg::status_t status;

  // sequencer: input transfer, estimate steps, depth-first walk
  cbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, segment stack and the output register
  cbf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cbf_datapath.sv =====
// datapath: flatness estimate, de casteljau split, segment stack and output register
`timescale 1ns / 1ps
`default_nettype none

module cbf_datapath (
  input  wire                     logic clk_i,
  input  wire                     logic rst_ni,
  input  wire cbf_pkg::cmd_t      cmd_i,
  output cbf_pkg::status_t        status_o,
  input  wire cbf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     logic out_stall_i,
  output cbf_pkg::out_item_t      out_data_o
);

`include "cubic_bezier_flattener_macros.svh"

  cbf_pkg::seg_t                      cur_q;
  cbf_pkg::seg_t                      stack_q [cbf_pkg::MAX_DEPTH];
  logic [cbf_pkg::CNT_W-1:0]          cnt_q;
  logic [cbf_pkg::DEPTH_W-1:0]        target_q;
  logic                               out_valid_q;
  cbf_pkg::out_item_t                 out_q;

  // estimate pipeline registers
  cbf_pkg::coord_t                    mid_x_q, mid_y_q;
  logic signed [cbf_pkg::DIFF_W-1:0]  dif_q [4];
  logic [cbf_pkg::DIFF_W-1:0]         mag_q [4];
  logic [cbf_pkg::DIST_W-1:0]         oct_q [2];
  logic [cbf_pkg::DIST_W-1:0]         dmax_q;
  logic [cbf_pkg::WHOLE_W-1:0]        whole_q;

  // first split level
  cbf_pkg::coord_t                    l1x_q [3];
  cbf_pkg::coord_t                    l1y_q [3];

  logic [cbf_pkg::CNT_W-1:0]          cnt_dec;
  logic [cbf_pkg::IDX_W-1:0]          push_idx, pop_idx;
  logic [cbf_pkg::DIST_W:0]           round_sum;
  logic                               out_free;
  cbf_pkg::coord_t                    a012x, a123x, midx, a012y, a123y, midy;

  assign cnt_dec   = cnt_q - cbf_pkg::CNT_W'(1);
  assign push_idx  = cnt_q[cbf_pkg::IDX_W-1:0];
  assign pop_idx   = cnt_dec[cbf_pkg::IDX_W-1:0];
  assign round_sum = {1'b0, dmax_q} + (cbf_pkg::DIST_W + 1)'(cbf_pkg::ROUND_ADD);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign a012x = cbf_pkg::avg2(l1x_q[0], l1x_q[1]);
  assign a123x = cbf_pkg::avg2(l1x_q[1], l1x_q[2]);
  assign midx  = cbf_pkg::avg2(a012x, a123x);
  assign a012y = cbf_pkg::avg2(l1y_q[0], l1y_q[1]);
  assign a123y = cbf_pkg::avg2(l1y_q[1], l1y_q[2]);
  assign midy  = cbf_pkg::avg2(a012y, a123y);

  assign status_o.leaf        = (cur_q.depth >= target_q);
  assign status_o.stack_empty = (cnt_q == '0);
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        cbf_pkg::OP_LOAD:    cnt_q    <= '0;
        cbf_pkg::OP_DEPTH:   target_q <= cbf_pkg::depth_of(whole_q);
        cbf_pkg::OP_SPLIT_B: cnt_q    <= cnt_q + cbf_pkg::CNT_W'(1);
        cbf_pkg::OP_EMIT: begin
          out_valid_q <= 1'b1;
          if (cnt_q != '0) begin
            cnt_q <= cnt_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cbf_pkg::OP_LOAD: begin
        cur_q.x     <= {in_data_i.p3_x, in_data_i.p2_x, in_data_i.p1_x, in_data_i.p0_x};
        cur_q.y     <= {in_data_i.p3_y, in_data_i.p2_y, in_data_i.p1_y, in_data_i.p0_y};
        cur_q.depth <= '0;
      end
      cbf_pkg::OP_MID: begin
        mid_x_q <= cbf_pkg::avg2(cur_q.x[0], cur_q.x[3]);
        mid_y_q <= cbf_pkg::avg2(cur_q.y[0], cur_q.y[3]);
      end
      cbf_pkg::OP_DIFF: begin
        dif_q[0] <= {mid_x_q[31], mid_x_q} - {cur_q.x[1][31], cur_q.x[1]};
        dif_q[1] <= {mid_y_q[31], mid_y_q} - {cur_q.y[1][31], cur_q.y[1]};
        dif_q[2] <= {mid_x_q[31], mid_x_q} - {cur_q.x[2][31], cur_q.x[2]};
        dif_q[3] <= {mid_y_q[31], mid_y_q} - {cur_q.y[2][31], cur_q.y[2]};
      end
      cbf_pkg::OP_ABS: begin
        for (int i = 0; i < 4; i++) begin
          mag_q[i] <= dif_q[i][cbf_pkg::DIFF_W-1] ? (~dif_q[i] + cbf_pkg::DIFF_W'(1))
                                                  : dif_q[i];
        end
      end
      cbf_pkg::OP_OCTA: begin
        oct_q[0] <= cbf_pkg::octa(mag_q[0], mag_q[1]);
        oct_q[1] <= cbf_pkg::octa(mag_q[2], mag_q[3]);
      end
      cbf_pkg::OP_MAX:   dmax_q  <= (oct_q[0] > oct_q[1]) ? oct_q[0] : oct_q[1];
      cbf_pkg::OP_ROUND: whole_q <= round_sum[cbf_pkg::DIST_W:cbf_pkg::FRAC_W];
      cbf_pkg::OP_SPLIT_A: begin
        l1x_q[0] <= cbf_pkg::avg2(cur_q.x[0], cur_q.x[1]);
        l1x_q[1] <= cbf_pkg::avg2(cur_q.x[1], cur_q.x[2]);
        l1x_q[2] <= cbf_pkg::avg2(cur_q.x[2], cur_q.x[3]);
        l1y_q[0] <= cbf_pkg::avg2(cur_q.y[0], cur_q.y[1]);
        l1y_q[1] <= cbf_pkg::avg2(cur_q.y[1], cur_q.y[2]);
        l1y_q[2] <= cbf_pkg::avg2(cur_q.y[2], cur_q.y[3]);
      end
      cbf_pkg::OP_SPLIT_B: begin
        // right half waits on the stack, left half carries on
        stack_q[push_idx].x     <= {cur_q.x[3], l1x_q[2], a123x, midx};
        stack_q[push_idx].y     <= {cur_q.y[3], l1y_q[2], a123y, midy};
        stack_q[push_idx].depth <= cur_q.depth + cbf_pkg::DEPTH_W'(1);
        cur_q.x     <= {midx, a012x, l1x_q[0], cur_q.x[0]};
        cur_q.y     <= {midy, a012y, l1y_q[0], cur_q.y[0]};
        cur_q.depth <= cur_q.depth + cbf_pkg::DEPTH_W'(1);
      end
      cbf_pkg::OP_EMIT: begin
        out_q.point_x    <= cur_q.x[3];
        out_q.point_y    <= cur_q.y[3];
        out_q.last_point <= (cnt_q == '0);
        if (cnt_q != '0) begin
          cur_q <= stack_q[pop_idx];
        end
      end
      default: ;
    endcase
  end

  `CBF_ASSERT_IMP(a_push_room, cmd_i.op == cbf_pkg::OP_SPLIT_B, cnt_q < cbf_pkg::CNT_W'(cbf_pkg::MAX_DEPTH), "segment stack overflow")
  `CBF_ASSERT_IMP(a_leaf_depth, cmd_i.op == cbf_pkg::OP_EMIT, cur_q.depth == target_q, "vertex emitted off target depth")
  `CBF_ASSERT_NEXT(a_emit_loads, cmd_i.op == cbf_pkg::OP_EMIT, out_valid_q, "emitted vertex not presented")

endmodule

`default_nettype wire

// ===== rtl/core/cbf_ctrl.sv =====
// controller: sequences the estimate, the split walk and vertex output
`timescale 1ns / 1ps
`default_nettype none

module cbf_ctrl (
  input  wire                   logic clk_i,
  input  wire                   logic rst_ni,
  input  wire                   logic in_valid_i,
  output logic                  in_stall_o,
  input  wire cbf_pkg::status_t status_i,
  output cbf_pkg::cmd_t         cmd_o
);

`include "cubic_bezier_flattener_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MID,
    ST_DIFF,
    ST_ABS,
    ST_OCTA,
    ST_MAX,
    ST_ROUND,
    ST_DEPTH,
    ST_WALK,
    ST_SPLIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  assign in_stall_o = stall_q;

  always_comb begin
    state_d   = state_q;
    stall_d   = stall_q;
    cmd_o.op  = cbf_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = cbf_pkg::OP_LOAD;
          state_d  = ST_MID;
          stall_d  = 1'b1;
        end
      end
      ST_MID: begin
        cmd_o.op = cbf_pkg::OP_MID;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = cbf_pkg::OP_DIFF;
        state_d  = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.op = cbf_pkg::OP_ABS;
        state_d  = ST_OCTA;
      end
      ST_OCTA: begin
        cmd_o.op = cbf_pkg::OP_OCTA;
        state_d  = ST_MAX;
      end
      ST_MAX: begin
        cmd_o.op = cbf_pkg::OP_MAX;
        state_d  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.op = cbf_pkg::OP_ROUND;
        state_d  = ST_DEPTH;
      end
      ST_DEPTH: begin
        cmd_o.op = cbf_pkg::OP_DEPTH;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        if (!status_i.leaf) begin
          cmd_o.op = cbf_pkg::OP_SPLIT_A;
          state_d  = ST_SPLIT;
        end else if (status_i.out_free) begin
          cmd_o.op = cbf_pkg::OP_EMIT;
          if (status_i.stack_empty) begin
            state_d = ST_IDLE;
            stall_d = 1'b0;
          end
        end
      end
      ST_SPLIT: begin
        cmd_o.op = cbf_pkg::OP_SPLIT_B;
        state_d  = ST_WALK;
      end
      default: begin
        state_d = ST_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  `CBF_ASSERT_IMP(a_emit_room, cmd_o.op == cbf_pkg::OP_EMIT, status_i.out_free, "vertex emitted into a full output register")
  `CBF_ASSERT_IMP(a_stall_idle, !stall_q, state_q == ST_IDLE, "input open outside idle")

endmodule

`default_nettype wire
